@@ rtl/dashed_line_raster_plotter_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the dashed line raster plotter.
// Each macro expects signals named clk and arst_n in the module that uses it.
// ---------------------------------------------------------------------------
`ifndef DASHED_LINE_RASTER_PLOTTER_UNIT_MACROS_SVH
`define DASHED_LINE_RASTER_PLOTTER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DLRP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dlrp: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define DLRP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dlrp: next-cycle check failed");

`endif

@@ rtl/dlrp_pkg.sv @@
// ---------------------------------------------------------------------------
// dlrp_pkg
// Shared types, codes and constants of the dashed line raster plotter.
// ---------------------------------------------------------------------------
`default_nettype none

package dlrp_pkg;

	// Default raster side is 2^9 = 512 pixels.
	localparam int SIDE_BITS_DEF = 9;
	// Tiles are 64x64 pixels, one 64-bit word per tile row.
	localparam int TILE_BITS     = 6;
	localparam int WORD_BITS     = 64;

	// Request codes.
	localparam logic [1:0] REQ_LINE  = 2'd0;
	localparam logic [1:0] REQ_POINT = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// Line style codes.
	localparam logic [2:0] STYLE_SOLID   = 3'd0;
	localparam logic [2:0] STYLE_DOTTED  = 3'd1;
	localparam logic [2:0] STYLE_SHORT   = 3'd2;
	localparam logic [2:0] STYLE_DOTDASH = 3'd3;
	localparam logic [2:0] STYLE_LONG    = 3'd4;

	// Dash pattern masks; zero means every pixel is drawn.
	localparam logic [5:0] MASK_NONE    = 6'o00;
	localparam logic [5:0] MASK_DOTTED  = 6'o14;
	localparam logic [5:0] MASK_SHORT   = 6'o34;
	localparam logic [5:0] MASK_DOTDASH = 6'o54;
	localparam logic [5:0] MASK_LONG    = 6'o74;

	// Input item.
	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
		logic [11:0]        word_address;
	} req_item_t;

	// Result item.
	typedef struct packed {
		logic [WORD_BITS-1:0] read_data;
		logic                 done_res;
	} rsp_item_t;

	// Command from the control FSM to the line stepper.
	typedef struct packed {
		logic               start;
		logic               point;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [15:0] ex;
		logic signed [15:0] ey;
	} stp_cmd_t;

	// Status of the read-modify-write unit.
	typedef struct packed {
		logic pending;
		logic clearing;
	} mem_stat_t;

	// Pattern mask of a line style; unused codes draw solid.
	function automatic logic [5:0] style_mask(input logic [2:0] style);
		logic [5:0] m;
		unique case (style)
			STYLE_DOTTED:  m = MASK_DOTTED;
			STYLE_SHORT:   m = MASK_SHORT;
			STYLE_DOTDASH: m = MASK_DOTDASH;
			STYLE_LONG:    m = MASK_LONG;
			default:       m = MASK_NONE;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

@@ rtl/dlrp_ram.sv @@
// ---------------------------------------------------------------------------
// dlrp_ram
// Generic single-write, single-read RAM with a registered read port.
// A read at the address being written returns the old contents.
// ---------------------------------------------------------------------------
`default_nettype none

module dlrp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Storage array and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/dlrp_stepper.sv @@
// ---------------------------------------------------------------------------
// dlrp_stepper
// Walks a line along its major axis with the two-accumulator error rule and
// emits one pixel per cycle, applying the dash pattern. Also emits single
// points without a pattern test.
// ---------------------------------------------------------------------------
`default_nettype none

module dlrp_stepper #(
	parameter int SIDE_BITS = dlrp_pkg::SIDE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire dlrp_pkg::stp_cmd_t            cmd,
	input  wire logic [2:0]                    line_style,
	output      logic                          busy,
	output      logic                          pix_vld,
	output      logic [2*SIDE_BITS-7:0]        pix_addr,
	output      logic [dlrp_pkg::TILE_BITS-1:0] pix_col
);

	import dlrp_pkg::*;

	localparam int AW = 2 * SIDE_BITS - TILE_BITS;

	typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_RUN, ST_POINT} stp_state_t;

	stp_state_t         state_q;
	logic signed [15:0] x_q, y_q, ex_q, ey_q;
	logic               xneg_q, yneg_q, xmaj_q;
	logic [15:0]        dmaj_q, dmin_q;
	logic [17:0]        acc1_q, acc2_q;

	logic [16:0] dx17, dy17, ndx17, ndy17;
	logic [15:0] adx, ady;
	logic        at_end, step_minor, pass;
	logic signed [15:0] px, py, x_inc, y_inc;
	logic [5:0]  mask, sum6;
	logic [18:0] acc2_sum;
	logic [17:0] acc1_next, acc2_next;
	logic [SIDE_BITS-1:0] ux, uy;

	// Line deltas and their magnitudes, used in the setup cycle.
	always_comb begin
		dx17  = {ex_q[15], ex_q} - {x_q[15], x_q};
		dy17  = {ey_q[15], ey_q} - {y_q[15], y_q};
		ndx17 = -dx17;
		ndy17 = -dy17;
		adx   = dx17[16] ? ndx17[15:0] : dx17[15:0];
		ady   = dy17[16] ? ndy17[15:0] : dy17[15:0];
	end

	// Current pixel: the endpoint once the major axis has reached it.
	always_comb begin
		at_end = xmaj_q ? (x_q == ex_q) : (y_q == ey_q);
		if (state_q == ST_RUN && at_end) begin
			px = ex_q;
			py = ey_q;
		end else begin
			px = x_q;
			py = y_q;
		end
	end

	// Dash pattern test on the low bits of x + slope*y.
	always_comb begin
		mask = style_mask(line_style);
		sum6 = (xneg_q ^ yneg_q) ? (px[5:0] - py[5:0]) : (px[5:0] + py[5:0]);
		pass = (mask == MASK_NONE) || ((sum6 & mask) != MASK_NONE);
	end

	// Error accumulators and coordinate steps.
	always_comb begin
		step_minor = acc1_q > acc2_q;
		acc2_sum   = ({1'b0, acc2_q} + {3'b000, dmaj_q}) - {1'b0, acc1_q};
		acc2_next  = step_minor ? acc2_sum[17:0] : acc2_q;
		acc1_next  = step_minor ? {2'b00, dmin_q} : acc1_q + {2'b00, dmin_q};
		x_inc      = xneg_q ? x_q - 16'sd1 : x_q + 16'sd1;
		y_inc      = yneg_q ? y_q - 16'sd1 : y_q + 16'sd1;
	end

	// Pixel output: word address within the tiled raster and column.
	always_comb begin
		ux       = px[SIDE_BITS-1:0];
		uy       = py[SIDE_BITS-1:0];
		pix_addr = AW'((32'(ux >> TILE_BITS) << TILE_BITS)
			| (32'(uy >> TILE_BITS) << SIDE_BITS)
			| 32'(uy[TILE_BITS-1:0]));
		pix_col  = px[TILE_BITS-1:0];
		pix_vld  = (state_q == ST_POINT) || (state_q == ST_RUN && pass);
		busy     = (state_q != ST_IDLE);
	end

	// Stepper sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						x_q     <= cmd.sx;
						y_q     <= cmd.sy;
						ex_q    <= cmd.ex;
						ey_q    <= cmd.ey;
						state_q <= cmd.point ? ST_POINT : ST_SETUP;
					end
				end
				ST_SETUP: begin
					xneg_q  <= dx17[16];
					yneg_q  <= dy17[16];
					xmaj_q  <= adx >= ady;
					dmaj_q  <= (adx >= ady) ? adx : ady;
					dmin_q  <= (adx >= ady) ? ady : adx;
					acc1_q  <= '0;
					acc2_q  <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (at_end) begin
						state_q <= ST_IDLE;
					end else begin
						acc1_q <= acc1_next;
						acc2_q <= acc2_next;
						if (xmaj_q) begin
							x_q <= x_inc;
							if (step_minor) begin
								y_q <= y_inc;
							end
						end else begin
							y_q <= y_inc;
							if (step_minor) begin
								x_q <= x_inc;
							end
						end
					end
				end
				ST_POINT: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/dlrp_rmw.sv @@
// ---------------------------------------------------------------------------
// dlrp_rmw
// Read-modify-write unit around the raster memory: sets one pixel per cycle
// with forwarding of the previous write, serves word reads, and clears the
// memory after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module dlrp_rmw #(
	parameter int DEPTH = 4096
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           pix_vld,
	input  wire logic [$clog2(DEPTH)-1:0]       pix_addr,
	input  wire logic [dlrp_pkg::TILE_BITS-1:0] pix_col,
	input  wire logic                           rd_req,
	input  wire logic [$clog2(DEPTH)-1:0]       rd_addr,
	output      logic                           rd_vld,
	output      logic [dlrp_pkg::WORD_BITS-1:0] rd_data,
	output      dlrp_pkg::mem_stat_t            stat
);

	`include "dashed_line_raster_plotter_unit_macros.svh"

	import dlrp_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam logic [WORD_BITS-1:0] LEFT_PIXEL = {1'b1, {(WORD_BITS-1){1'b0}}};

	logic                 clr_active_q;
	logic [AW-1:0]        clr_addr_q;
	logic                 vld_s1, rd_s1;
	logic [AW-1:0]        addr_s1;
	logic [TILE_BITS-1:0] col_s1;
	logic                 wvld_q;
	logic [AW-1:0]        waddr_q;
	logic [WORD_BITS-1:0] wdata_q;

	logic [AW-1:0]        ram_raddr, ram_waddr;
	logic [WORD_BITS-1:0] ram_rdata, ram_wdata, base, merged;
	logic                 ram_we;

	dlrp_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Read port: word reads and pixel reads never arrive together.
	assign ram_raddr = rd_req ? rd_addr : pix_addr;

	// Merge: take the previous write when it hit the same word.
	always_comb begin
		base   = (wvld_q && waddr_q == addr_s1) ? wdata_q : ram_rdata;
		merged = base | (LEFT_PIXEL >> col_s1);
	end

	// Write port: the clearing sweep owns it after reset.
	always_comb begin
		ram_we    = clr_active_q || (vld_s1 && !rd_s1);
		ram_waddr = clr_active_q ? clr_addr_q : addr_s1;
		ram_wdata = clr_active_q ? '0 : merged;
	end

	assign rd_vld        = vld_s1 && rd_s1;
	assign rd_data       = base;
	assign stat.pending  = vld_s1;
	assign stat.clearing = clr_active_q;

	// Clearing sweep, one word per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// Pipeline stage one and the forwarding register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			wvld_q <= 1'b0;
		end else begin
			vld_s1 <= pix_vld || rd_req;
			wvld_q <= vld_s1 && !rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		rd_s1   <= rd_req;
		addr_s1 <= rd_req ? rd_addr : pix_addr;
		col_s1  <= pix_col;
		waddr_q <= addr_s1;
		wdata_q <= merged;
	end

	// No request may overlap the clearing sweep.
	`DLRP_ASSERT_SAME(a_no_op_while_clearing, clr_active_q, !vld_s1)
	// Pixel and word requests are exclusive.
	`DLRP_ASSERT_SAME(a_req_exclusive, pix_vld, !rd_req)
	// A forwarded write never comes from the sweep.
	`DLRP_ASSERT_SAME(a_fwd_after_clear, wvld_q, !clr_active_q)

endmodule

`default_nettype wire

@@ rtl/dashed_line_raster_plotter_unit.sv @@
// ---------------------------------------------------------------------------
// dashed_line_raster_plotter_unit
// Tiled one-bit raster with dashed line drawing, point setting and word reads.
// ---------------------------------------------------------------------------
// Usage:
// Requests enter on req (req_valid/req_stall), one at a time; every request
// gives exactly one result on rsp (rsp_valid/rsp_stall) with done_res set and
// read_data holding the raster word for reads, zero otherwise.
// Line style is written over the APB port at address 0 while the unit is idle.
// The line time is set by the stepper; the raster memory takes one pixel
// read-modify-write per cycle along the major axis; a request is accepted
// again the cycle after its result is loaded.
// After reset the unit sweeps all 2^(2*RASTER_SIDE_BITS-6) memory words (4096
// at the default) to zero, one word per cycle, holding req_stall high
// meanwhile; the APB port works throughout.
// A stalled result waits in the output register; the next request is still
// accepted and runs, and its result waits until that register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module dashed_line_raster_plotter_unit #(
	parameter int RASTER_SIDE_BITS = dlrp_pkg::SIDE_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output      logic                req_stall,
	input  wire dlrp_pkg::req_item_t req,
	output      logic                rsp_valid,
	input  wire logic                rsp_stall,
	output      dlrp_pkg::rsp_item_t rsp,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output      logic [31:0]         prdata,
	output      logic                pready
);

	`include "dashed_line_raster_plotter_unit_macros.svh"

	import dlrp_pkg::*;

	localparam int AW    = 2 * RASTER_SIDE_BITS - TILE_BITS;
	localparam int DEPTH = 1 << AW;
	localparam logic REG_LINE_STYLE = 1'b0;

	typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_RDWAIT, ST_FIN} ctl_state_t;

	ctl_state_t           state_q;
	logic [2:0]           style_q;
	logic [WORD_BITS-1:0] res_data_q;
	logic                 out_vld_q;
	rsp_item_t            out_q;

	logic                 accept, out_free, stp_busy, pix_vld, rd_req, rd_vld;
	logic [AW-1:0]        pix_addr, rd_addr;
	logic [TILE_BITS-1:0] pix_col;
	logic [AW+11:0]       word_ext;
	logic [WORD_BITS-1:0] rd_data;
	stp_cmd_t             cmd;
	mem_stat_t            stat;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LINE_STYLE) ? {29'd0, style_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			style_q <= STYLE_SOLID;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_LINE_STYLE) begin
			style_q <= pwdata[2:0];
		end
	end

	// Input handshake and dispatch.
	always_comb begin
		req_stall = (state_q != ST_IDLE) || stat.clearing;
		accept    = req_valid && !req_stall;
		cmd.start = accept && (req.req_type == REQ_LINE || req.req_type == REQ_POINT);
		cmd.point = req.req_type == REQ_POINT;
		cmd.sx    = req.start_x;
		cmd.sy    = req.start_y;
		cmd.ex    = req.end_x;
		cmd.ey    = req.end_y;
		rd_req    = accept && req.req_type == REQ_READ;
		word_ext  = {{AW{1'b0}}, req.word_address};
		rd_addr   = word_ext[AW-1:0];
		out_free  = !out_vld_q || !rsp_stall;
	end

	dlrp_stepper #(
		.SIDE_BITS(RASTER_SIDE_BITS)
	) u_stepper (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.line_style(style_q),
		.busy      (stp_busy),
		.pix_vld   (pix_vld),
		.pix_addr  (pix_addr),
		.pix_col   (pix_col)
	);

	dlrp_rmw #(
		.DEPTH(DEPTH)
	) u_rmw (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_vld (pix_vld),
		.pix_addr(pix_addr),
		.pix_col (pix_col),
		.rd_req  (rd_req),
		.rd_addr (rd_addr),
		.rd_vld  (rd_vld),
		.rd_data (rd_data),
		.stat    (stat)
	);

	// Control FSM and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			res_data_q <= '0;
			out_vld_q  <= 1'b0;
			out_q      <= '0;
		end else begin
			// The finish state reloads the register itself when it frees.
			if (out_vld_q && !rsp_stall && state_q != ST_FIN) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_data_q <= '0;
						unique case (req.req_type)
							REQ_LINE, REQ_POINT: state_q <= ST_BUSY;
							REQ_READ:            state_q <= ST_RDWAIT;
							default:             state_q <= ST_FIN;
						endcase
					end
				end
				ST_BUSY: begin
					if (!stp_busy && !stat.pending) begin
						state_q <= ST_FIN;
					end
				end
				ST_RDWAIT: begin
					if (rd_vld) begin
						res_data_q <= rd_data;
						state_q    <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_vld_q       <= 1'b1;
						out_q.read_data <= res_data_q;
						out_q.done_res  <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

	// Read data only comes back while a read is outstanding.
	`DLRP_ASSERT_SAME(a_rd_only_in_wait, rd_vld, state_q == ST_RDWAIT)
	// The stepper never runs during the clearing sweep.
	`DLRP_ASSERT_SAME(a_no_pixel_in_clear, stat.clearing, !pix_vld && !stp_busy)
	// A finished request is presented once the output register frees.
	`DLRP_ASSERT_NEXT(a_fin_loads_out, state_q == ST_FIN && out_free, rsp_valid)

endmodule

`default_nettype wire

@@ tb/tb_dashed_line_raster_plotter_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dashed_line_raster_plotter_unit
// Self-checking bench for the tiled raster plotter. A shadow raster in the
// bench redraws every accepted line and point and predicts each word read.
// Every response is compared with the oldest prediction. A short directed
// run covers wrapped coordinates, lines along both major axes, degenerate and
// full-range lines, and the unused request code. Random phases follow, one per line
// style, with varying back-pressure on both channels.
// ---------------------------------------------------------------------------

module tb_dashed_line_raster_plotter_unit;
	import dlrp_pkg::*;

	localparam int RASTER_SIDE_BITS = SIDE_BITS_DEF;
	localparam int RASTER_SIDE = 1 << RASTER_SIDE_BITS;
	localparam int RASTER_WORDS = 1 << (2 * RASTER_SIDE_BITS - TILE_BITS);
	localparam int TILES_PER_ROW = 1 << (RASTER_SIDE_BITS - TILE_BITS);
	localparam int CYCLE_LIMIT = 2000000;
	localparam int TAIL_CYCLES = 20;
	localparam int LONG_HOLD_CYCLES = 400;

	// Codes that the package leaves unnamed.
	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam logic [2:0] STYLE_SPARE_LO = 3'd5;
	localparam logic [2:0] STYLE_SPARE_HI = 3'd7;
	localparam logic [2:0] LINE_STYLE_ADDR = 3'd0;

	// Shadow copy of the raster, with the queue of predicted responses.
	class raster_shadow;
		logic [63:0] words [RASTER_WORDS];
		logic [2:0] style;
		rsp_item_t expected_q [$];
		int unsigned failures;

		function new();
			foreach (words[i]) words[i] = '0;
			style = STYLE_SOLID;
			failures = 0;
		endfunction

		// Word address of a pixel after wrapping both coordinates.
		function logic [11:0] word_of(int x, int y);
			int ux;
			int uy;
			int tile;
			ux = x & (RASTER_SIDE - 1);
			uy = y & (RASTER_SIDE - 1);
			tile = (ux >> TILE_BITS) + (uy >> TILE_BITS) * TILES_PER_ROW;
			return 12'(((tile << TILE_BITS) + (uy & 63)) & (RASTER_WORDS - 1));
		endfunction

		function void set_pixel(int x, int y);
			int ux;
			ux = x & 63;
			words[word_of(x, y)][63 - ux] = 1'b1;
		endfunction

		// Dash mask of the current style; spare codes draw solid.
		function logic [5:0] dash_mask();
			case (style)
				STYLE_DOTTED: return MASK_DOTTED;
				STYLE_SHORT: return MASK_SHORT;
				STYLE_DOTDASH: return MASK_DOTDASH;
				STYLE_LONG: return MASK_LONG;
				default: return MASK_NONE;
			endcase
		endfunction

		function void plot(int x, int y, int slope);
			logic [5:0] mask;
			int phase;
			mask = dash_mask();
			phase = x + slope * y;
			if (mask == MASK_NONE || (phase[5:0] & mask) != 6'd0) begin
				set_pixel(x, y);
			end
		endfunction

		// Steps the major axis; the minor axis moves when the running error
		// passes its limit, and the limit then absorbs the error.
		function void draw(int x0, int y0, int x1, int y1);
			int dx;
			int dy;
			int xstep;
			int ystep;
			int slope;
			longint err_run;
			longint err_limit;
			dx = x1 - x0;
			dy = y1 - y0;
			xstep = 1;
			ystep = 1;
			err_run = 0;
			err_limit = 0;
			if (dx < 0) begin
				xstep = -1;
				dx = -dx;
			end
			if (dy < 0) begin
				ystep = -1;
				dy = -dy;
			end
			slope = xstep * ystep;
			if (dx >= dy) begin
				while (x0 != x1) begin
					plot(x0, y0, slope);
					if (err_run > err_limit) begin
						err_limit += longint'(dx) - err_run;
						err_run = 0;
						y0 += ystep;
					end
					err_run += dy;
					x0 += xstep;
				end
			end else begin
				while (y0 != y1) begin
					plot(x0, y0, slope);
					if (err_run > err_limit) begin
						err_limit += longint'(dy) - err_run;
						err_run = 0;
						x0 += xstep;
					end
					err_run += dx;
					y0 += ystep;
				end
			end
			plot(x1, y1, slope);
		endfunction

		// Applies an accepted request and queues the response it must give.
		function void accept_request(req_item_t item);
			rsp_item_t want;
			want.read_data = '0;
			want.done_res = 1'b1;
			case (item.req_type)
				REQ_LINE: draw($signed(item.start_x), $signed(item.start_y),
					$signed(item.end_x), $signed(item.end_y));
				REQ_POINT: set_pixel($signed(item.start_x), $signed(item.start_y));
				REQ_READ: want.read_data = words[int'(item.word_address) & (RASTER_WORDS - 1)];
				default: ;
			endcase
			expected_q.push_back(want);
		endfunction

		function void check_response(rsp_item_t got);
			rsp_item_t want;
			if (expected_q.size() == 0) begin
				$error("response with none pending: read_data %h done_res %b",
					got.read_data, got.done_res);
				failures++;
				return;
			end
			want = expected_q.pop_front();
			if (got.read_data !== want.read_data) begin
				$error("read_data: expected %h, got %h", want.read_data, got.read_data);
				failures++;
			end
			if (got.done_res !== want.done_res) begin
				$error("done_res: expected %b, got %b", want.done_res, got.done_res);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_item_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_item_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	raster_shadow shadow = new();
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int hold_ask = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int recent_x = 0;
	int recent_y = 0;
	int recent_ex = 0;
	int recent_ey = 0;

	dashed_line_raster_plotter_unit #(
		.RASTER_SIDE_BITS(RASTER_SIDE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Guard against a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("dashed_line_raster_plotter_unit regression: fail");
			$finish;
		end
	end

	// Response side: check each accepted item, then pick the next stall.
	// A requested long hold is counted down here at every clock edge.
	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && !rsp_stall) begin
			shadow.check_response(rsp);
		end
		if (hold_ask > 0) begin
			hold_left = hold_ask;
			hold_ask = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic req_item_t make_request(logic [1:0] kind, int sx, int sy, int ex,
		int ey, logic [11:0] addr);
		req_item_t item;
		item.req_type = kind;
		item.start_x = 16'(sx);
		item.start_y = 16'(sy);
		item.end_x = 16'(ex);
		item.end_y = 16'(ey);
		item.word_address = addr;
		return item;
	endfunction

	// Pick an end coordinate near the start without leaving the 16-bit range.
	function automatic int near_coord(int base, int reach);
		int offset;
		offset = int'($urandom_range(2 * reach)) - reach;
		if (base + offset > 32767 || base + offset < -32768) begin
			offset = -offset;
		end
		return base + offset;
	endfunction

	// Mostly short lines, some longer ones; reads favor recently drawn words.
	function automatic req_item_t random_request();
		req_item_t item;
		int pick;
		int reach;
		int sx;
		int sy;
		int ex;
		int ey;
		logic [11:0] addr;
		pick = $urandom_range(99);
		sx = $urandom_range(65535) - 32768;
		sy = $urandom_range(65535) - 32768;
		ex = $urandom_range(65535) - 32768;
		ey = $urandom_range(65535) - 32768;
		addr = 12'($urandom_range(4095));
		if (pick < 45) begin
			reach = ($urandom_range(9) == 0) ? 600 : 40;
			ex = near_coord(sx, reach);
			ey = near_coord(sy, reach);
			recent_x = sx;
			recent_y = sy;
			recent_ex = ex;
			recent_ey = ey;
			item = make_request(REQ_LINE, sx, sy, ex, ey, addr);
		end else if (pick < 65) begin
			recent_x = sx;
			recent_y = sy;
			item = make_request(REQ_POINT, sx, sy, ex, ey, addr);
		end else if (pick < 95) begin
			case ($urandom_range(9))
				0, 1, 2, 3: addr = shadow.word_of(recent_x, recent_y);
				4, 5, 6: addr = shadow.word_of(recent_ex, recent_ey);
				default: ;
			endcase
			item = make_request(REQ_READ, sx, sy, ex, ey, addr);
		end else begin
			item = make_request(REQ_NONE, sx, sy, ex, ey, addr);
		end
		return item;
	endfunction

	// Offer one item after a random gap and hold it until it is taken.
	task automatic send_request(input req_item_t item);
		while ($urandom_range(99) < send_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall !== 1'b0) @(posedge clk);
		shadow.accept_request(item);
	endtask

	task automatic wait_drained();
		while (shadow.expected_q.size() != 0) @(posedge clk);
	endtask

	// APB write of the line style: setup cycle, then access until ready.
	task automatic write_line_style(input logic [2:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LINE_STYLE_ADDR;
		pwdata <= {29'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		shadow.style = value;
	endtask

	// One random phase: drain, restyle while idle, then stream items.
	task automatic run_phase(input logic [2:0] style_code, input int send_pct,
		input int recv_pct, input int count);
		req_valid <= 1'b0;
		wait_drained();
		write_line_style(style_code);
		send_gap_pct = send_pct;
		recv_stall_pct = recv_pct;
		repeat (count) send_request(random_request());
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_line_style(STYLE_SOLID);
		send_gap_pct = 21;
		recv_stall_pct = 62;

		// Directed: cleared words, wrapped points, lines along both major axes, a
		// lone endpoint, the unused request code and two full-range lines.
		send_request(make_request(REQ_READ, 0, 0, 0, 0, 12'd0));
		send_request(make_request(REQ_READ, -1, -1, -1, -1, 12'd4095));
		send_request(make_request(REQ_POINT, 0, 0, 0, 0, 12'd0));
		send_request(make_request(REQ_POINT, -1, -1, 0, 0, 12'd4095));
		send_request(make_request(REQ_POINT, 32767, -32768, -32768, 32767, 12'd0));
		send_request(make_request(REQ_READ, 0, 0, 0, 0, 12'd0));
		send_request(make_request(REQ_READ, 0, 0, 0, 0, 12'd4095));
		send_request(make_request(REQ_READ, 0, 0, 0, 0, shadow.word_of(32767, -32768)));
		send_request(make_request(REQ_LINE, 10, 10, 10, 10, 12'd0));
		send_request(make_request(REQ_LINE, 100, 100, 120, 105, 12'd0));
		send_request(make_request(REQ_LINE, 100, 200, 80, 195, 12'd0));
		send_request(make_request(REQ_LINE, 200, 100, 205, 120, 12'd0));
		send_request(make_request(REQ_LINE, 200, 200, 195, 180, 12'd0));
		send_request(make_request(REQ_LINE, 300, 300, 310, 290, 12'd0));
		send_request(make_request(REQ_LINE, -5, 3, 5, 3, 12'd0));
		send_request(make_request(REQ_NONE, -1, -1, -1, -1, 12'd4095));
		send_request(make_request(REQ_READ, 0, 0, 0, 0, shadow.word_of(100, 100)));
		send_request(make_request(REQ_READ, 0, 0, 0, 0, shadow.word_of(110, 102)));
		send_request(make_request(REQ_READ, 0, 0, 0, 0, shadow.word_of(203, 110)));
		send_request(make_request(REQ_READ, 0, 0, 0, 0, shadow.word_of(0, 3)));
		send_request(make_request(REQ_LINE, -32768, 5, 32767, -7, 12'd0));
		send_request(make_request(REQ_LINE, 3, 32767, -2, -32768, 12'd0));
		send_request(make_request(REQ_READ, 0, 0, 0, 0, shadow.word_of(0, 0)));
		send_request(make_request(REQ_READ, 0, 0, 0, 0, shadow.word_of(3, 200)));

		// Random phases through the dashed styles and a spare code.
		run_phase(STYLE_DOTTED, 21, 62, 75);
		run_phase(STYLE_SHORT, 21, 62, 75);
		run_phase(STYLE_DOTDASH, 62, 21, 75);
		run_phase(STYLE_LONG, 62, 21, 75);
		run_phase(STYLE_SPARE_HI, 62, 21, 75);

		// The receiver holds off for a long stretch while items keep coming,
		// so the block fills and stalls its input.
		run_phase(STYLE_SPARE_LO, 0, 0, 0);
		hold_ask = LONG_HOLD_CYCLES;
		repeat (75) send_request(random_request());
		run_phase(STYLE_SOLID, 0, 0, 75);

		req_valid <= 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (shadow.failures == 0 && shadow.expected_q.size() == 0) begin
			$display("dashed_line_raster_plotter_unit regression: pass");
		end else begin
			$display("dashed_line_raster_plotter_unit regression: fail");
		end
		$finish;
	end

endmodule

@@ dashed_line_raster_plotter_unit.f @@
+incdir+rtl
rtl/dlrp_pkg.sv
rtl/dlrp_ram.sv
rtl/dlrp_stepper.sv
rtl/dlrp_rmw.sv
rtl/dashed_line_raster_plotter_unit.sv
tb/tb_dashed_line_raster_plotter_unit.sv
